>>> sv/bms_uart_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery-monitor frame decoder
// Shared property forms; each use names its own label, clock and reset.
// ----------------------------------------------------------------------------
`ifndef BMS_UART_FRAME_DECODER_ASSERT_SVH
`define BMS_UART_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define BUFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bms_uart_frame_decoder: same-cycle check failed");

// next-cycle implication
`define BUFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bms_uart_frame_decoder: next-cycle check failed");

`endif

>>> sv/bufd_pkg.sv
// ----------------------------------------------------------------------------
// bufd_pkg
// Types, codes and constants shared by the frame decoder modules.
// ----------------------------------------------------------------------------
package bufd_pkg;

   localparam logic [7:0]  START_BYTE = 8'hDD;
   localparam logic [7:0]  STOP_BYTE  = 8'h77;
   localparam logic [7:0]  TYPE_BASIC = 8'h03;
   localparam logic [7:0]  TYPE_CELLS = 8'h04;
   localparam logic [7:0]  TYPE_FET   = 8'hE1;
   localparam logic [15:0] CELL_START = 16'd5000;
   localparam logic [7:0]  FET_INDEX  = 8'd20;
   localparam logic [7:0]  TEMP_INDEX = 8'd23;

   localparam int CELL_COUNT    = 4;   // 1 .. 16
   localparam int SENSOR_COUNT  = 2;   // 1 .. 2
   localparam int QUEUE_DEPTH   = 4;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TYPE,
      PH_STATUS,
      PH_LEN,
      PH_DATA,
      PH_SUMHI,
      PH_SUMLO,
      PH_STOP
   } phase_type;

   typedef enum logic [2:0] {
      OUT_BASIC     = 3'd0,
      OUT_CELLS     = 3'd1,
      OUT_FET       = 3'd2,
      OUT_UNKNOWN   = 3'd3,
      OUT_STOP_ERR  = 3'd4,
      OUT_SUM_ERR   = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      CMD_CLEAR,
      CMD_VOLT,
      CMD_CURR,
      CMD_TEMP1,
      CMD_TEMP2,
      CMD_FET,
      CMD_CELL,
      CMD_STOP
   } cmd_kind_type;

   // one queued request from the parser to the result side
   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  word;        // captured word; low byte alone for CMD_FET
      logic [7:0]   frame_type;
      logic         stop_ok;
      logic         sum_ok;
   } cmd_type;

   typedef struct packed {
      logic [15:0]        cell_spread_mv;
      logic [15:0]        cell_max_mv;
      logic [12:0]        cell_min_mv;
      logic [15:0]        temp_second;
      logic [15:0]        temp_first;
      logic               discharge_on;
      logic               charge_on;
      logic [7:0]         fet_state;
      logic signed [15:0] pack_current;
      logic [15:0]        pack_voltage;
      logic [7:0]         frame_type;
      outcome_type        outcome;
   } result_type;

endpackage

>>> sv/bufd_queue.sv
// ----------------------------------------------------------------------------
// bufd_queue
// Small first-in first-out queue of parser requests.
// ----------------------------------------------------------------------------
module bufd_queue
   import bufd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    in_ready,
   input  logic    pop,
   output logic    out_valid,
   output cmd_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign do_push   = push && in_ready;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> sv/bufd_front.sv
// ----------------------------------------------------------------------------
// bufd_front
// Frame parser: tracks the frame phase and checksum, turns bytes into requests.
// ----------------------------------------------------------------------------
module bufd_front
   import bufd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] rx_byte,
   output logic       cmd_valid,
   output cmd_type    cmd
);

   localparam logic [7:0] CELL_LIMIT = 8'(2 * CELL_COUNT);

   phase_type   phase_ff, phase_in;
   logic [7:0]  type_ff;
   logic [7:0]  len_ff;
   logic [7:0]  index_ff;
   logic [7:0]  index_next;
   logic [15:0] sum_ff;
   logic [7:0]  sum_hi_ff;
   logic [7:0]  pend_ff;

   assign index_next = index_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HUNT:   phase_in = (rx_byte == START_BYTE) ? PH_TYPE : PH_HUNT;
            PH_TYPE:   phase_in = PH_STATUS;
            PH_STATUS: phase_in = PH_LEN;
            PH_LEN:    phase_in = (rx_byte == 8'd0) ? PH_SUMHI : PH_DATA;
            PH_DATA:   phase_in = (index_next == len_ff) ? PH_SUMHI : PH_DATA;
            PH_SUMHI:  phase_in = PH_SUMLO;
            PH_SUMLO:  phase_in = PH_STOP;
            PH_STOP:   phase_in = PH_HUNT;
            default:   phase_in = PH_HUNT;
         endcase
      end
   end

   // request generation
   always_comb begin
      cmd_valid      = 1'b0;
      cmd.kind       = CMD_CLEAR;
      cmd.word       = {pend_ff, rx_byte};
      cmd.frame_type = type_ff;
      cmd.stop_ok    = (rx_byte == STOP_BYTE);
      cmd.sum_ok     = (sum_ff == 16'd0);
      unique case (phase_ff)
         PH_HUNT: begin
            cmd_valid = byte_valid && (rx_byte == START_BYTE);
         end
         PH_DATA: begin
            priority if (type_ff == TYPE_BASIC) begin
               priority if (index_ff == 8'd1) begin
                  cmd_valid = byte_valid;
                  cmd.kind  = CMD_VOLT;
               end else if (index_ff == 8'd3) begin
                  cmd_valid = byte_valid;
                  cmd.kind  = CMD_CURR;
               end else if (index_ff == FET_INDEX) begin
                  cmd_valid = byte_valid;
                  cmd.kind  = CMD_FET;
               end else if (index_ff == TEMP_INDEX + 8'd1) begin
                  cmd_valid = byte_valid;
                  cmd.kind  = CMD_TEMP1;
               end else if (index_ff == TEMP_INDEX + 8'd3 && SENSOR_COUNT >= 2) begin
                  cmd_valid = byte_valid;
                  cmd.kind  = CMD_TEMP2;
               end else begin
                  cmd_valid = 1'b0;
               end
            end else if (type_ff == TYPE_CELLS) begin
               cmd_valid = byte_valid && index_ff[0] && (index_ff < CELL_LIMIT);
               cmd.kind  = CMD_CELL;
            end else if (type_ff == TYPE_FET) begin
               cmd_valid = byte_valid && (index_ff == 8'd1);
               cmd.kind  = CMD_FET;
            end else begin
               cmd_valid = 1'b0;
            end
         end
         PH_STOP: begin
            cmd_valid = byte_valid;
            cmd.kind  = CMD_STOP;
         end
         default: begin
            cmd_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // frame bookkeeping; checksum, index and pending byte are set again at the start byte
   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff   <= '0;
         len_ff    <= '0;
         index_ff  <= '0;
         sum_ff    <= '0;
         sum_hi_ff <= '0;
         pend_ff   <= '0;
      end else if (byte_valid) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == START_BYTE) begin
                  sum_ff   <= '0;
                  index_ff <= '0;
                  pend_ff  <= '0;
               end
            end
            PH_TYPE: begin
               type_ff <= rx_byte;
            end
            PH_STATUS: begin
               sum_ff <= sum_ff - {8'd0, rx_byte};
            end
            PH_LEN: begin
               sum_ff   <= sum_ff - {8'd0, rx_byte};
               len_ff   <= rx_byte;
               index_ff <= '0;
            end
            PH_DATA: begin
               sum_ff   <= sum_ff - {8'd0, rx_byte};
               pend_ff  <= rx_byte;
               index_ff <= index_next;
            end
            PH_SUMHI: begin
               sum_hi_ff <= rx_byte;
            end
            PH_SUMLO: begin
               // zero exactly when the checksum matches
               sum_ff <= sum_ff ^ {sum_hi_ff, rx_byte};
            end
            default: begin
               sum_ff <= sum_ff;
            end
         endcase
      end
   end

endmodule

>>> sv/bufd_back.sv
// ----------------------------------------------------------------------------
// bufd_back
// Result side: applies captures and builds one registered result per frame.
// ----------------------------------------------------------------------------
module bufd_back
   import bufd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   logic [15:0] word_ff [4];
   logic [7:0]  fet_ff;
   logic [15:0] low_ff;
   logic [15:0] high_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, rsp_in;
   logic        slot_free;
   logic        take;
   logic        emit;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (cmd.kind != CMD_STOP) || slot_free;
   assign take      = cmd_valid && cmd_ready;
   assign emit      = take && (cmd.kind == CMD_STOP);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // result assembly; fields that do not belong to the outcome stay zero
   always_comb begin
      rsp_in            = '0;
      rsp_in.frame_type = cmd.frame_type;
      priority if (!cmd.stop_ok) begin
         rsp_in.outcome = OUT_STOP_ERR;
      end else if (!cmd.sum_ok) begin
         rsp_in.outcome = OUT_SUM_ERR;
      end else if (cmd.frame_type == TYPE_BASIC) begin
         rsp_in.outcome      = OUT_BASIC;
         rsp_in.pack_voltage = word_ff[0];
         rsp_in.pack_current = word_ff[1];
         rsp_in.fet_state    = fet_ff;
         rsp_in.charge_on    = fet_ff[0];
         rsp_in.discharge_on = fet_ff[1];
         rsp_in.temp_first   = word_ff[2];
         rsp_in.temp_second  = word_ff[3];
      end else if (cmd.frame_type == TYPE_CELLS) begin
         rsp_in.outcome        = OUT_CELLS;
         rsp_in.cell_min_mv    = low_ff[12:0];
         rsp_in.cell_max_mv    = high_ff;
         rsp_in.cell_spread_mv = (high_ff >= low_ff) ? high_ff - low_ff : 16'd0;
      end else if (cmd.frame_type == TYPE_FET) begin
         rsp_in.outcome      = OUT_FET;
         rsp_in.fet_state    = fet_ff;
         rsp_in.charge_on    = fet_ff[0];
         rsp_in.discharge_on = fet_ff[1];
      end else begin
         rsp_in.outcome = OUT_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '{default: '0};
         fet_ff  <= '0;
         low_ff  <= CELL_START;
         high_ff <= '0;
      end else if (take) begin
         unique case (cmd.kind)
            CMD_CLEAR: begin
               word_ff <= '{default: '0};
               fet_ff  <= '0;
               low_ff  <= CELL_START;
               high_ff <= '0;
            end
            CMD_VOLT:  word_ff[0] <= cmd.word;
            CMD_CURR:  word_ff[1] <= cmd.word;
            CMD_TEMP1: word_ff[2] <= cmd.word;
            CMD_TEMP2: word_ff[3] <= cmd.word;
            CMD_FET:   fet_ff     <= cmd.word[7:0];
            CMD_CELL: begin
               if (cmd.word < low_ff) begin
                  low_ff <= cmd.word;
               end
               if (cmd.word > high_ff) begin
                  high_ff <= cmd.word;
               end
            end
            CMD_STOP: begin
               fet_ff <= fet_ff;
            end
            default: begin
               fet_ff <= fet_ff;
            end
         endcase
      end
   end

endmodule

>>> sv/bms_uart_frame_decoder.sv
// ----------------------------------------------------------------------------
// bms_uart_frame_decoder
// Decodes battery-monitor reply frames from a received byte stream.
//
//   channel  direction  payload                               carries
//   req_     in         tdata[7:0] rx_byte                    one received byte
//   rsp_     out        tuser outcome, tdata decoded fields   one result per frame
//
// Flow: one byte per cycle while the queue has room; a stop byte's request
//   leaves the request queue once nothing is ahead of it, then its result is registered.
// The parser judges framing and checksum; the result side captures fields.
// Reset: synchronous, clears phase, queue and output valid; no clearing pass.
// Stalls: while rsp_tready is low, requests collect in the queue and
//   req_tready drops only once the queue is full.
// ----------------------------------------------------------------------------
module bms_uart_frame_decoder
   import bufd_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] frame_type, [23:8] pack_voltage, [39:24] pack_current,
   // [47:40] fet_state, [48] charge_on, [49] discharge_on,
   // [65:50] temp_first, [81:66] temp_second, [94:82] cell_min_mv,
   // [110:95] cell_max_mv, [126:111] cell_spread_mv, [127] zero
   output logic [127:0] rsp_tdata,
   output logic [2:0]   rsp_tuser    // [2:0] outcome
);

   logic       byte_valid;
   logic       front_valid;
   cmd_type    front_cmd;
   logic       queue_valid;
   cmd_type    queue_cmd;
   logic       back_ready;
   result_type result;

   // accept a byte whenever the queue can take a request
   assign byte_valid = req_tvalid && req_tready;

   bufd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(byte_valid),
      .rx_byte   (req_tdata),
      .cmd_valid (front_valid),
      .cmd       (front_cmd)
   );

   bufd_queue #(
      .DEPTH(QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .push_data(front_cmd),
      .in_ready (req_tready),
      .pop      (back_ready),
      .out_valid(queue_valid),
      .out_data (queue_cmd)
   );

   bufd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(queue_valid),
      .cmd      (queue_cmd),
      .cmd_ready(back_ready),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp      (result)
   );

   // pack the result, first field in the lowest bits
   assign rsp_tuser = result.outcome;
   assign rsp_tdata = {1'b0,
                       result.cell_spread_mv,
                       result.cell_max_mv,
                       result.cell_min_mv,
                       result.temp_second,
                       result.temp_first,
                       result.discharge_on,
                       result.charge_on,
                       result.fet_state,
                       result.pack_current,
                       result.pack_voltage,
                       result.frame_type};

endmodule

>>> sv/bufd_checker.sv
// ----------------------------------------------------------------------------
// bufd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`include "bms_uart_frame_decoder_assert.svh"

module bufd_checker
   import bufd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   `BUFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `BUFD_ASSERT_IMP(a_err_fields_zero, clock, reset, rsp_tvalid && (rsp_tuser == OUT_STOP_ERR || rsp_tuser == OUT_SUM_ERR || rsp_tuser == OUT_UNKNOWN), rsp_tdata[127:8] == '0)

   `BUFD_ASSERT_IMP(a_min_capped, clock, reset, rsp_tvalid && rsp_tuser == OUT_CELLS, rsp_tdata[94:82] <= CELL_START[12:0])

   `BUFD_ASSERT_IMP(a_spread, clock, reset, rsp_tvalid && rsp_tuser == OUT_CELLS && rsp_tdata[110:95] >= {3'd0, rsp_tdata[94:82]}, rsp_tdata[126:111] == rsp_tdata[110:95] - {3'd0, rsp_tdata[94:82]})

endmodule

bind bms_uart_frame_decoder bufd_checker u_bufd_checker (.*);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - battery-monitor frame decoder testbench
// Feeds received bytes (noise, well-formed and damaged reply frames) through
// the request channel with random gaps, decodes the same stream in a local
// model and checks every result field as it leaves the result channel.
// ----------------------------------------------------------------------------
module tb;
   import bufd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 50;
   localparam int LONG_HOLD    = 300;

   typedef enum logic [1:0] {
      FRAME_GOOD,
      FRAME_BAD_STOP,
      FRAME_BAD_SUM
   } frame_flaw_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   bms_uart_frame_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // shared run control
   int  mismatches      = 0;
   bit  calm            = 1'b0;  // no random gaps on either side while set
   int  hold_cycles_req = 0;     // receiver holds off this long at next chance
   int  frames_judged   = 0;
   int  frame_bytes     = 0;

   // ---------------------------------------------------------------------
   // Frame decoding model: mirrors the parser state byte by byte
   // ---------------------------------------------------------------------
   phase_type   fr_phase   = PH_HUNT;
   logic [7:0]  fr_type    = 8'h00;
   logic [7:0]  fr_len     = 8'h00;
   logic [7:0]  fr_idx     = 8'h00;
   logic [15:0] fr_sum     = 16'h0000;
   logic [7:0]  fr_sum_hi  = 8'h00;
   logic [7:0]  fr_prev    = 8'h00;
   logic [15:0] fr_words [4] = '{default: 16'h0000};
   logic [7:0]  fr_fet     = 8'h00;
   logic [15:0] fr_cell_lo = CELL_START;
   logic [15:0] fr_cell_hi = 16'h0000;

   result_type  awaited_results [$];

   // request bytes of the frame under construction
   logic [7:0]  frame_payload [$];

   function automatic void clear_capture();
      for (int k = 0; k < 4; k++) fr_words[k] = 16'h0000;
      fr_fet     = 8'h00;
      fr_cell_lo = CELL_START;
      fr_cell_hi = 16'h0000;
      fr_prev    = 8'h00;
   endfunction

   // capture fields from one data byte; words are big-endian byte pairs
   function automatic void absorb_data(input logic [7:0] b);
      logic [15:0] w;
      w = {fr_prev, b};
      if (fr_type == TYPE_BASIC) begin
         if (fr_idx == 8'd1)                                fr_words[0] = w;
         else if (fr_idx == 8'd3)                           fr_words[1] = w;
         else if (fr_idx == FET_INDEX)                      fr_fet      = b;
         else if (fr_idx == TEMP_INDEX + 8'd1 && SENSOR_COUNT >= 1) fr_words[2] = w;
         else if (fr_idx == TEMP_INDEX + 8'd3 && SENSOR_COUNT >= 2) fr_words[3] = w;
      end else if (fr_type == TYPE_CELLS) begin
         if (fr_idx[0] && int'(fr_idx) < 2 * CELL_COUNT) begin
            if (w < fr_cell_lo) fr_cell_lo = w;
            if (w > fr_cell_hi) fr_cell_hi = w;
         end
      end else if (fr_type == TYPE_FET) begin
         if (fr_idx == 8'd1) fr_fet = b;
      end
      fr_prev = b;
   endfunction

   // advance the model by one accepted byte; queue a result at the stop slot
   function automatic void decode_rx_byte(input logic [7:0] b);
      result_type r;
      if (fr_phase != PH_HUNT || b == START_BYTE) frame_bytes++;
      case (fr_phase)
         PH_HUNT: begin
            if (b == START_BYTE) begin
               clear_capture();
               fr_sum   = 16'h0000;
               fr_idx   = 8'h00;
               fr_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            fr_type  = b;
            fr_phase = PH_STATUS;
         end
         PH_STATUS: begin
            fr_sum   = fr_sum - b;
            fr_phase = PH_LEN;
         end
         PH_LEN: begin
            fr_sum = fr_sum - b;
            fr_len = b;
            fr_idx = 8'h00;
            if (b == 8'h00) fr_phase = PH_SUMHI;
            else            fr_phase = PH_DATA;
         end
         PH_DATA: begin
            fr_sum = fr_sum - b;
            absorb_data(b);
            fr_idx = fr_idx + 8'd1;
            if (fr_idx == fr_len) fr_phase = PH_SUMHI;
         end
         PH_SUMHI: begin
            fr_sum_hi = b;
            fr_phase  = PH_SUMLO;
         end
         PH_SUMLO: begin
            // zero exactly when the received checksum matches
            fr_sum   = fr_sum ^ {fr_sum_hi, b};
            fr_phase = PH_STOP;
         end
         default: begin
            fr_phase     = PH_HUNT;
            r            = '0;
            r.frame_type = fr_type;
            if (b != STOP_BYTE) begin
               r.outcome = OUT_STOP_ERR;
            end else if (fr_sum != 16'h0000) begin
               r.outcome = OUT_SUM_ERR;
            end else if (fr_type == TYPE_BASIC) begin
               r.outcome      = OUT_BASIC;
               r.pack_voltage = fr_words[0];
               r.pack_current = fr_words[1];
               r.fet_state    = fr_fet;
               r.charge_on    = fr_fet[0];
               r.discharge_on = fr_fet[1];
               r.temp_first   = fr_words[2];
               r.temp_second  = fr_words[3];
            end else if (fr_type == TYPE_CELLS) begin
               r.outcome     = OUT_CELLS;
               r.cell_min_mv = fr_cell_lo[12:0];
               r.cell_max_mv = fr_cell_hi;
               // no cell word seen leaves max below min: spread reads zero
               r.cell_spread_mv = (fr_cell_hi >= fr_cell_lo) ? fr_cell_hi - fr_cell_lo
                                                             : 16'h0000;
            end else if (fr_type == TYPE_FET) begin
               r.outcome      = OUT_FET;
               r.fet_state    = fr_fet;
               r.charge_on    = fr_fet[0];
               r.discharge_on = fr_fet[1];
            end else begin
               r.outcome = OUT_UNKNOWN;
            end
            awaited_results.push_back(r);
            frames_judged++;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with no frame pending, expected none, got outcome %0d",
                     $time, rsp_tuser);
         end else begin
            want = awaited_results.pop_front();
            check_field("outcome",        want.outcome,                 rsp_tuser);
            check_field("frame_type",     want.frame_type,              rsp_tdata[7:0]);
            check_field("pack_voltage",   want.pack_voltage,            rsp_tdata[23:8]);
            check_field("pack_current",   $unsigned(want.pack_current), rsp_tdata[39:24]);
            check_field("fet_state",      want.fet_state,               rsp_tdata[47:40]);
            check_field("charge_on",      want.charge_on,               rsp_tdata[48]);
            check_field("discharge_on",   want.discharge_on,            rsp_tdata[49]);
            check_field("temp_first",     want.temp_first,              rsp_tdata[65:50]);
            check_field("temp_second",    want.temp_second,             rsp_tdata[81:66]);
            check_field("cell_min_mv",    want.cell_min_mv,             rsp_tdata[94:82]);
            check_field("cell_max_mv",    want.cell_max_mv,             rsp_tdata[110:95]);
            check_field("cell_spread_mv", want.cell_spread_mv,          rsp_tdata[126:111]);
            check_field("tdata pad",      32'd0,                        rsp_tdata[127]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall per result, long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : receiver
      int w;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles_req > 0) begin
            w               = hold_cycles_req;
            hold_cycles_req = 0;
         end else begin
            w = calm ? 0 : $urandom_range(0, 9);
         end
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         // hold ready until a result goes, or a hold-off is asked for
         do @(posedge clock); while (!rsp_tvalid && hold_cycles_req == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // offer one byte after a random gap; return at the edge that takes it
   task automatic send_rx_byte(input logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      decode_rx_byte(b);
   endtask

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == START_BYTE);
      return b;
   endfunction

   function automatic void load_payload(input int len);
      frame_payload.delete();
      for (int k = 0; k < len; k++) frame_payload.push_back(8'($urandom));
   endfunction

   // cell words mostly near real cell voltages, high byte first
   function automatic void load_cell_payload(input int len);
      frame_payload.delete();
      for (int k = 0; k < len; k++) begin
         if (k % 2 == 0 && $urandom_range(0, 9) < 7)
            frame_payload.push_back(8'($urandom_range(8'h0A, 8'h15)));
         else
            frame_payload.push_back(8'($urandom));
      end
   endfunction

   function automatic void put_word(input int idx, input logic [15:0] w);
      frame_payload[idx]     = w[15:8];
      frame_payload[idx + 1] = w[7:0];
   endfunction

   // wrap the loaded payload in start, header, checksum and stop bytes
   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] status,
                             input frame_flaw_type flaw);
      logic [15:0] sum;
      logic [7:0]  stop_b;
      sum = 16'h0000 - status - 8'(frame_payload.size());
      foreach (frame_payload[k]) sum = sum - frame_payload[k];
      if (flaw == FRAME_BAD_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
      stop_b = STOP_BYTE;
      if (flaw == FRAME_BAD_STOP) begin
         do stop_b = 8'($urandom); while (stop_b == STOP_BYTE);
      end
      send_rx_byte(START_BYTE);
      send_rx_byte(ftype);
      send_rx_byte(status);
      send_rx_byte(8'(frame_payload.size()));
      foreach (frame_payload[k]) send_rx_byte(frame_payload[k]);
      send_rx_byte(sum[15:8]);
      send_rx_byte(sum[7:0]);
      send_rx_byte(stop_b);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_noise_and_basic_info();
      // drop everything until a start byte
      send_rx_byte(8'h00);
      send_rx_byte(8'hFF);
      send_rx_byte(STOP_BYTE);
      send_rx_byte(TYPE_BASIC);
      load_payload(27);
      put_word(0, 16'hFFFF);
      put_word(2, 16'h8000);
      frame_payload[FET_INDEX] = 8'h03;
      put_word(TEMP_INDEX, 16'h0000);
      put_word(TEMP_INDEX + 2, 16'hFFFF);
      send_frame(TYPE_BASIC, 8'h00, FRAME_GOOD);
      load_payload(27);
      put_word(0, 16'h0000);
      put_word(2, 16'h7FFF);
      frame_payload[FET_INDEX] = 8'hFC;
      put_word(TEMP_INDEX, 16'h0BA6);
      put_word(TEMP_INDEX + 2, 16'h0BB0);
      send_frame(TYPE_BASIC, 8'hFF, FRAME_GOOD);
   endtask

   task automatic test_short_frames();
      // missing data bytes leave their fields at zero
      load_payload(4);
      put_word(0, 16'h1234);
      put_word(2, 16'hFF38);
      send_frame(TYPE_BASIC, 8'h00, FRAME_GOOD);
      load_payload(0);
      send_frame(TYPE_BASIC, 8'h00, FRAME_GOOD);
      load_payload(22);
      send_frame(TYPE_BASIC, 8'h00, FRAME_GOOD);
   endtask

   task automatic test_cell_extremes();
      load_payload(10);
      put_word(0, 16'd3300);
      put_word(2, 16'd3350);
      put_word(4, 16'd3280);
      put_word(6, 16'd3400);
      send_frame(TYPE_CELLS, 8'h00, FRAME_GOOD);
      // cells above the start value never lower the minimum
      load_payload(8);
      put_word(0, 16'd5100);
      put_word(2, 16'd6000);
      put_word(4, 16'hFFFF);
      put_word(6, 16'd5001);
      send_frame(TYPE_CELLS, 8'h00, FRAME_GOOD);
      // no cell word at all: spread clamps to zero
      load_payload(0);
      send_frame(TYPE_CELLS, 8'h00, FRAME_GOOD);
      load_payload(3);
      put_word(0, 16'd0);
      send_frame(TYPE_CELLS, 8'h00, FRAME_GOOD);
   endtask

   task automatic test_fet_reply();
      load_payload(2);
      frame_payload[1] = 8'h02;
      send_frame(TYPE_FET, 8'h00, FRAME_GOOD);
      load_payload(2);
      frame_payload[1] = 8'hFD;
      send_frame(TYPE_FET, 8'h80, FRAME_GOOD);
      // FET state byte never arrives
      load_payload(1);
      send_frame(TYPE_FET, 8'h00, FRAME_GOOD);
   endtask

   task automatic test_unknown_types();
      load_payload(3);
      send_frame(8'h05, 8'h00, FRAME_GOOD);
      load_payload(0);
      send_frame(8'h00, 8'hFF, FRAME_GOOD);
      // long payload well past every capture slot
      load_payload(60);
      send_frame(8'hFF, 8'h00, FRAME_GOOD);
   endtask

   task automatic test_framing_errors();
      // a start byte in the stop slot is consumed as the stop error
      load_payload(2);
      send_frame(TYPE_FET, 8'h00, FRAME_GOOD);
      frame_payload.delete();
      send_rx_byte(START_BYTE);
      send_rx_byte(TYPE_CELLS);
      send_rx_byte(8'h00);
      send_rx_byte(8'h00);
      send_rx_byte(8'h12);
      send_rx_byte(8'h34);
      send_rx_byte(START_BYTE);
      load_payload(8);
      send_frame(TYPE_CELLS, 8'h00, FRAME_GOOD);
      load_payload(27);
      send_frame(TYPE_BASIC, 8'h00, FRAME_BAD_SUM);
      load_payload(27);
      send_frame(TYPE_BASIC, 8'h00, FRAME_BAD_STOP);
      // start bytes inside the frame are content only
      load_payload(8);
      put_word(0, {START_BYTE, START_BYTE});
      put_word(4, {8'h0C, START_BYTE});
      send_frame(TYPE_CELLS, START_BYTE, FRAME_GOOD);
   endtask

   task automatic test_back_to_back();
      calm = 1'b1;
      load_payload(27);
      send_frame(TYPE_BASIC, 8'h00, FRAME_GOOD);
      load_cell_payload(8);
      send_frame(TYPE_CELLS, 8'h00, FRAME_GOOD);
      load_payload(2);
      send_frame(TYPE_FET, 8'h00, FRAME_GOOD);
      load_payload(0);
      send_frame(8'h42, 8'h00, FRAME_BAD_SUM);
      calm = 1'b0;
   endtask

   task automatic test_output_backpressure();
      // hold the result side off so the queue fills and requests stall
      hold_cycles_req = LONG_HOLD;
      calm            = 1'b1;
      repeat (4) begin
         load_cell_payload(2 * CELL_COUNT);
         send_frame(TYPE_CELLS, 8'h00, FRAME_GOOD);
         load_payload(2);
         send_frame(TYPE_FET, 8'h00, FRAME_GOOD);
      end
      calm = 1'b0;
   endtask

   task automatic test_random_traffic();
      int start_bytes;
      int start_judged;
      int pick;
      int len;
      frame_flaw_type flaw;
      start_bytes  = frame_bytes;
      start_judged = frames_judged;
      while (frame_bytes - start_bytes < 100 || frames_judged - start_judged < 6) begin
         if ($urandom_range(0, 7) == 0) calm = !calm;
         if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) send_rx_byte(noise_byte());
         pick = $urandom_range(0, 9);
         flaw = (pick == 0) ? FRAME_BAD_STOP : (pick == 1) ? FRAME_BAD_SUM : FRAME_GOOD;
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            len = ($urandom_range(0, 2) != 0) ? 27 : $urandom_range(0, 40);
            load_payload(len);
            send_frame(TYPE_BASIC, 8'($urandom), flaw);
         end else if (pick < 45) begin
            load_cell_payload($urandom_range(0, 2 * CELL_COUNT + 3));
            send_frame(TYPE_CELLS, 8'($urandom), flaw);
         end else if (pick < 65) begin
            load_payload($urandom_range(0, 4));
            send_frame(TYPE_FET, 8'($urandom), flaw);
         end else if (pick < 80) begin
            load_payload($urandom_range(0, 6));
            send_frame(8'($urandom), 8'($urandom), flaw);
         end else begin
            // broken frame: the bytes that follow complete it
            len = $urandom_range(0, 6);
            send_rx_byte(START_BYTE);
            send_rx_byte(8'($urandom));
            send_rx_byte(8'($urandom));
            send_rx_byte(8'(len));
            repeat ($urandom_range(0, len + 5)) send_rx_byte(8'($urandom));
         end
      end
      calm = 1'b0;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Sequence and watchdog
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_noise_and_basic_info();
      test_short_frames();
      test_cell_extremes();
      test_fet_reply();
      test_unknown_types();
      test_framing_errors();
      test_back_to_back();
      test_output_backpressure();
      test_random_traffic();
      drain_results();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : watchdog
      int ticks;
      ticks = 0;
      while (ticks < CYCLE_LIMIT) begin
         @(posedge clock);
         ticks++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> bms_uart_frame_decoder.f
+incdir+sv
sv/bufd_pkg.sv
sv/bufd_queue.sv
sv/bufd_front.sv
sv/bufd_back.sv
sv/bms_uart_frame_decoder.sv
sv/bufd_checker.sv
test/tb.sv
